/* hw/rtl/tpgr_pkg.sv */
package tpgr_pkg;

  localparam int unsigned FIELD_W = 24;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned CMP_W   = FIELD_W + 1;

  localparam logic [FIELD_W-1:0] PERIOD_RESET = 24'd1000;

  typedef struct packed {
    logic [FIELD_W-1:0] tdc_a;
    logic [FIELD_W-1:0] tdc_b;
    logic               in_last;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] out_a;
    logic [FIELD_W-1:0] out_b;
    logic [FIELD_W-1:0] mean_gap;
    logic               out_last;
  } out_t;

  // Results of one pass through the shared gap unit.
  typedef struct packed {
    logic far;       // twice the gap exceeds the period
    logic close;     // twice the gap is below the period
    logic moved_lt;  // the gap itself is below the period
  } cmp_t;

endpackage

/* hw/rtl/tpgr_diff.sv */
module tpgr_diff #(
  parameter int unsigned TW = 24
) (
  input  logic [TW-1:0]                  x_i,
  input  logic [TW-1:0]                  y_i,
  input  logic [tpgr_pkg::FIELD_W-1:0]   period_i,
  output logic [TW-1:0]                  diff_o,
  output tpgr_pkg::cmp_t                 cmp_o
);

  localparam int unsigned CW = tpgr_pkg::CMP_W;

  logic [CW-1:0] twice;
  logic [CW-1:0] per;
  logic [CW-1:0] once;

  assign diff_o = (x_i > y_i) ? (x_i - y_i) : (y_i - x_i);
  assign twice  = CW'({diff_o, 1'b0});
  assign once   = CW'(diff_o);
  assign per    = CW'(period_i);

  assign cmp_o.far      = (twice > per);
  assign cmp_o.close    = (twice < per);
  assign cmp_o.moved_lt = (once < per);

endmodule

/* hw/rtl/tpgr_div.sv */
module tpgr_div #(
  parameter int unsigned DW = 40,
  parameter int unsigned VW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int unsigned STW = $clog2(DW);

  logic           busy_q;
  logic           done_q;
  logic [STW-1:0] step_q;
  logic [DW-1:0]  quo_q;
  logic [VW-1:0]  rem_q;
  logic [VW-1:0]  dvs_q;
  logic [VW:0]    shifted;
  logic [VW:0]    diff;
  logic           ge;

  // One quotient bit per cycle, restoring form.
  assign shifted = {rem_q, quo_q[DW-1]};
  assign ge      = (shifted >= {1'b0, dvs_q});
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? diff[VW-1:0] : shifted[VW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* hw/rtl/tdc_pair_glitch_realigner.sv */
// A corrected item passes the far, close, move and sum steps, then shows its result in the
// emit step; a run's third item shows the raw oldest pair in the cycle after it is taken.
// A new item is taken only in the idle state. The one shared gap unit makes six passes (far
// with the first close check, two more close checks, two moves, sum). A last item runs the
// divider (40 quotient bits, one a cycle), then flushes the held pairs, the last with the mean
// gap. Reset (rst_ni low, asynchronous) clears the run state and sets the period to 1000 ps.
module tdc_pair_glitch_realigner #(
  parameter int unsigned MAX_SAMPLES = 65536,
  parameter int unsigned TIME_BITS   = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tpgr_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tpgr_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [tpgr_pkg::FIELD_W-1:0]   cfg_wdata_i
);

  localparam int unsigned FW   = tpgr_pkg::FIELD_W;
  localparam int unsigned SW   = tpgr_pkg::SUM_W;
  localparam int unsigned TW   = (TIME_BITS < FW) ? TIME_BITS : FW;
  localparam int unsigned CNTW = $clog2(MAX_SAMPLES + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FAR   = 4'd1;
  localparam logic [3:0] ST_CL1   = 4'd2;
  localparam logic [3:0] ST_CL2   = 4'd3;
  localparam logic [3:0] ST_MVA   = 4'd4;
  localparam logic [3:0] ST_MVB   = 4'd5;
  localparam logic [3:0] ST_SUM   = 4'd6;
  localparam logic [3:0] ST_EMIT  = 4'd7;
  localparam logic [3:0] ST_SHIFT = 4'd8;
  localparam logic [3:0] ST_DIV   = 4'd9;
  localparam logic [3:0] ST_FL0   = 4'd10;
  localparam logic [3:0] ST_FL1   = 4'd11;

  logic [3:0]      state_q, state_d;
  logic [FW-1:0]   period_q;
  logic [TW-1:0]   xa_q, xb_q;
  logic            last_q;
  logic [TW-1:0]   h0a_q, h0b_q, h1a_q, h1b_q;
  logic [TW-1:0]   prev_a_q, prev_b_q;
  logic [TW-1:0]   res_a_q, res_b_q;
  logic            fix_a_q, fix_b_q;
  logic            far_q, cl_q, mva_q;
  logic [SW-1:0]   gap_sum_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [FW-1:0]   mean_q;

  logic [TW-1:0]   u_x, u_y, u_diff;
  tpgr_pkg::cmp_t  u_cmp;
  logic [TW-1:0]   ca_sel, cb_sel;
  logic [SW:0]     sum_ext;
  logic            in_acc, out_acc;
  logic            div_start, div_done;
  logic [SW-1:0]   div_quot;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  assign ca_sel  = fix_a_q ? h1a_q : h0a_q;
  assign cb_sel  = fix_b_q ? h1b_q : h0b_q;
  assign sum_ext = {1'b0, gap_sum_q} + (SW + 1)'(u_diff);
  assign cnt_d   = (cnt_q < CNTW'(MAX_SAMPLES)) ? (cnt_q + 1'b1) : cnt_q;

  // Operands of the shared gap unit for each step.
  always_comb begin
    u_x = h0a_q;
    u_y = h0b_q;
    unique case (state_q)
      ST_CL1: begin
        u_x = h1a_q;
        u_y = h1b_q;
      end
      ST_CL2: begin
        u_x = xa_q;
        u_y = xb_q;
      end
      ST_MVA: begin
        u_x = h0a_q;
        u_y = prev_a_q;
      end
      ST_MVB: begin
        u_x = h0b_q;
        u_y = prev_b_q;
      end
      ST_SUM: begin
        u_x = ca_sel;
        u_y = cb_sel;
      end
      default: begin
        u_x = h0a_q;
        u_y = h0b_q;
      end
    endcase
  end

  tpgr_diff #(
    .TW(TW)
  ) u_diff_unit (
    .x_i     (u_x),
    .y_i     (u_y),
    .period_i(period_q),
    .diff_o  (u_diff),
    .cmp_o   (u_cmp)
  );

  assign div_start = (state_q == ST_SHIFT) && last_q;

  tpgr_div #(
    .DW(SW),
    .VW(CNTW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(gap_sum_q),
    .divisor_i (cnt_d),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cnt_q >= CNTW'(3)) begin
            state_d = ST_FAR;
          end else if (cnt_q >= CNTW'(2)) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_SHIFT;
          end
        end
      end
      ST_FAR:   state_d = ST_CL1;
      ST_CL1:   state_d = ST_CL2;
      ST_CL2:   state_d = ST_MVA;
      ST_MVA:   state_d = ST_MVB;
      ST_MVB:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_ready_i) begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: state_d = last_q ? ST_DIV : ST_IDLE;
      ST_DIV: begin
        if (div_done) begin
          state_d = (cnt_q >= CNTW'(2)) ? ST_FL0 : ST_FL1;
        end
      end
      ST_FL0: begin
        if (out_ready_i) begin
          state_d = ST_FL1;
        end
      end
      ST_FL1: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      period_q  <= tpgr_pkg::PERIOD_RESET;
      h0a_q     <= '0;
      h0b_q     <= '0;
      h1a_q     <= '0;
      h1b_q     <= '0;
      prev_a_q  <= '0;
      prev_b_q  <= '0;
      fix_a_q   <= 1'b0;
      fix_b_q   <= 1'b0;
      gap_sum_q <= '0;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          // Early in a run the oldest pair goes out raw.
          if (in_acc && (cnt_q == CNTW'(2))) begin
            prev_a_q <= h0a_q;
            prev_b_q <= h0b_q;
          end
        end
        ST_MVB: begin
          if (far_q) begin
            if (!fix_a_q && !fix_b_q) begin
              if (mva_q) begin
                fix_a_q <= 1'b1;
              end else if (u_cmp.moved_lt) begin
                fix_b_q <= 1'b1;
              end
            end
          end else if (cl_q) begin
            fix_a_q <= 1'b0;
            fix_b_q <= 1'b0;
          end
        end
        ST_SUM: begin
          gap_sum_q <= sum_ext[SW] ? '1 : sum_ext[SW-1:0];
          prev_a_q  <= ca_sel;
          prev_b_q  <= cb_sel;
        end
        ST_SHIFT: begin
          h0a_q <= h1a_q;
          h0b_q <= h1b_q;
          h1a_q <= xa_q;
          h1b_q <= xb_q;
          cnt_q <= cnt_d;
        end
        ST_FL1: begin
          if (out_ready_i) begin
            h0a_q     <= '0;
            h0b_q     <= '0;
            h1a_q     <= '0;
            h1b_q     <= '0;
            prev_a_q  <= '0;
            prev_b_q  <= '0;
            fix_a_q   <= 1'b0;
            fix_b_q   <= 1'b0;
            gap_sum_q <= '0;
            cnt_q     <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      xa_q   <= in_data_i.tdc_a[TW-1:0];
      xb_q   <= in_data_i.tdc_b[TW-1:0];
      last_q <= in_data_i.in_last;
      // Early in a run the raw oldest pair is the result.
      res_a_q <= h0a_q;
      res_b_q <= h0b_q;
    end
    unique case (state_q)
      ST_FAR: begin
        far_q <= u_cmp.far;
        cl_q  <= u_cmp.close;
      end
      ST_CL1:  cl_q  <= cl_q && u_cmp.close;
      ST_CL2:  cl_q  <= cl_q && u_cmp.close;
      ST_MVA:  mva_q <= u_cmp.moved_lt;
      ST_SUM: begin
        res_a_q <= ca_sel;
        res_b_q <= cb_sel;
      end
      ST_DIV: begin
        if (div_done) begin
          mean_q <= (|div_quot[SW-1:FW]) ? '1 : div_quot[FW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT) || (state_q == ST_FL0) || (state_q == ST_FL1);

  always_comb begin
    out_data_o = '0;
    unique case (state_q)
      ST_EMIT: begin
        out_data_o.out_a = FW'(res_a_q);
        out_data_o.out_b = FW'(res_b_q);
      end
      ST_FL0: begin
        out_data_o.out_a = FW'(h0a_q);
        out_data_o.out_b = FW'(h0b_q);
      end
      ST_FL1: begin
        out_data_o.out_a    = FW'(h1a_q);
        out_data_o.out_b    = FW'(h1b_q);
        out_data_o.mean_gap = mean_q;
        out_data_o.out_last = 1'b1;
      end
      default: begin
        out_data_o = '0;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_one_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fix_a_q && fix_b_q))
    else $error("both correction flags set");

  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_data_o.out_last) |=> (cnt_q == '0 && gap_sum_q == '0))
    else $error("run state not cleared after last result");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the wait step");

endmodule
